@@ sv/ort_pkg.sv @@
// ----------------------------------------------------------------------------
// ort_pkg
// Shared types and constants for the occupancy region offset table.
// ----------------------------------------------------------------------------
`default_nettype none

package ort_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned WORD_IDX_W = 15;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned COORD_W    = 3;
  localparam int unsigned COUNT_W    = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [WORD_IDX_W-1:0] word_index;
    logic [WORD_W-1:0]     grid_word;
    logic [COORD_W-1:0]    region_x;
    logic [COORD_W-1:0]    region_y;
    logic [COORD_W-1:0]    region_z;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] offset;
    logic [COUNT_W-1:0] occupied_total;
    logic               is_occupied;
  } out_t;

endpackage

`default_nettype wire

@@ sv/ort_flag_mem.sv @@
// ----------------------------------------------------------------------------
// ort_flag_mem
// Region flag store: one row of flags per (y, z) pair, bit x within the row.
// Row valid flops clear all rows at once; invalid rows read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ort_flag_mem #(
  parameter int unsigned REGIONS_PER_AXIS = 8,
  localparam int unsigned ROWS  = REGIONS_PER_AXIS * REGIONS_PER_AXIS,
  localparam int unsigned ROW_W = $clog2(ROWS),
  localparam int unsigned BIT_W = $clog2(REGIONS_PER_AXIS)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clr_i,
  input  wire logic                        wr_en_i,
  input  wire logic [ROW_W-1:0]            wr_row_i,
  input  wire logic [BIT_W-1:0]            wr_bit_i,
  input  wire logic [ROW_W-1:0]            rd_row_i,
  output logic      [REGIONS_PER_AXIS-1:0] rd_bits_o
);

  logic [REGIONS_PER_AXIS-1:0] mem_q [ROWS];
  logic [ROWS-1:0]             row_vld_q;
  logic [REGIONS_PER_AXIS-1:0] rd_data_q;
  logic                        rd_vld_q;
  logic [REGIONS_PER_AXIS-1:0] wr_onehot;

  assign wr_onehot = REGIONS_PER_AXIS'(1) << wr_bit_i;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (row_vld_q[wr_row_i]) begin
        mem_q[wr_row_i][wr_bit_i] <= 1'b1;
      end else begin
        mem_q[wr_row_i] <= wr_onehot;
      end
    end
    rd_data_q <= mem_q[rd_row_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (clr_i) begin
        row_vld_q <= '0;
      end else if (wr_en_i) begin
        row_vld_q[wr_row_i] <= 1'b1;
      end
      rd_vld_q <= row_vld_q[rd_row_i];
    end
  end

  assign rd_bits_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ sv/ort_scan.sv @@
// ----------------------------------------------------------------------------
// ort_scan
// Query sequencer: walks the flag rows in linear order, one row digit per
// cycle, accumulating the total count and the count ahead of the target.
// ----------------------------------------------------------------------------
`default_nettype none

module ort_scan #(
  parameter int unsigned REGIONS_PER_AXIS = 8,
  localparam int unsigned ROWS  = REGIONS_PER_AXIS * REGIONS_PER_AXIS,
  localparam int unsigned ROW_W = $clog2(ROWS)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [ort_pkg::COORD_W-1:0]         qx_i,
  input  wire logic [ROW_W-1:0]                    trow_i,
  input  wire logic                                inside_i,
  output logic      [ROW_W-1:0]                    rd_row_o,
  input  wire logic [REGIONS_PER_AXIS-1:0]         rd_bits_i,
  output logic                                     done_o,
  output ort_pkg::out_t                            result_o
);

  import ort_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROWS * REGIONS_PER_AXIS + 1);
  localparam int unsigned IDX_W = COORD_W + 2;

  function automatic logic [CNT_W-1:0] popcnt(input logic [REGIONS_PER_AXIS-1:0] v);
    logic [CNT_W-1:0] s;
    s = '0;
    for (int i = 0; i < REGIONS_PER_AXIS; i++) begin
      s = s + CNT_W'(v[i]);
    end
    return s;
  endfunction

  logic                        run_q;
  logic [ROW_W-1:0]            cnt_q;
  logic                        dvld_q;
  logic                        dlast_q;
  logic [ROW_W-1:0]            drow_q;
  logic                        done_q;
  logic [COORD_W-1:0]          qx_q;
  logic [ROW_W-1:0]            trow_q;
  logic                        inside_q;
  logic [CNT_W-1:0]            total_q;
  logic [CNT_W-1:0]            before_q;
  logic                        occ_q;
  logic                        last_row;
  logic [REGIONS_PER_AXIS-1:0] low_mask;
  logic [REGIONS_PER_AXIS-1:0] sel_mask;
  logic [CNT_W-1:0]            pop_all;
  logic [CNT_W-1:0]            pop_low;

  assign last_row = (cnt_q == ROW_W'(ROWS - 1));

  always_comb begin
    for (int i = 0; i < REGIONS_PER_AXIS; i++) begin
      low_mask[i] = (IDX_W'(i) < {2'b00, qx_q});
      sel_mask[i] = (IDX_W'(i) == {2'b00, qx_q});
    end
    pop_all = popcnt(rd_bits_i);
    pop_low = popcnt(rd_bits_i & low_mask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cnt_q   <= '0;
      dvld_q  <= 1'b0;
      dlast_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      dvld_q  <= run_q;
      dlast_q <= run_q && last_row;
      done_q  <= dvld_q && dlast_q;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + ROW_W'(1);
        if (last_row) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    drow_q <= cnt_q;
    if (start_i) begin
      qx_q     <= qx_i;
      trow_q   <= trow_i;
      inside_q <= inside_i;
      total_q  <= '0;
      before_q <= '0;
      occ_q    <= 1'b0;
    end else if (dvld_q) begin
      total_q <= total_q + pop_all;
      if (inside_q) begin
        if (drow_q < trow_q) begin
          before_q <= before_q + pop_all;
        end else if (drow_q == trow_q) begin
          before_q <= before_q + pop_low;
          occ_q    <= |(rd_bits_i & sel_mask);
        end
      end
    end
  end

  assign rd_row_o                = cnt_q;
  assign done_o                  = done_q;
  assign result_o.offset         = occ_q ? COUNT_W'(before_q) : COUNT_W'(total_q);
  assign result_o.occupied_total = COUNT_W'(total_q);
  assign result_o.is_occupied    = occ_q;

endmodule

`default_nettype wire

@@ sv/occupancy_region_offset_table.sv @@
// ----------------------------------------------------------------------------
// occupancy_region_offset_table
// Region occupancy flags of a Morton-ordered occupancy grid, with compacted
// offset queries.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) takes three commands:
// load a 64-bit grid word, query a region, clear all region flags. Loads and
// clears are taken one per cycle while no query is in flight and give no
// result; a nonzero word sets its region's flag through the registered load
// stage, ahead of any later query. A query walks the R*R flag rows, one row
// per cycle, in linear order. Its result leaves on the output channel
// (out_valid_o / out_stall_i / out_item_o) through the output register;
// input stays stalled until the result is registered, so a new query is
// taken only once the last one's result is. The output register holds a
// stalled result while new loads and clears keep flowing; a finished query
// waits in the scan unit if the output register is still occupied.
// Reset clears all flags at once (row valid flops); no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_region_offset_table #(
  parameter int unsigned REGIONS_PER_AXIS = 8,
  parameter int unsigned REGION_SIDE      = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ort_pkg::in_t  in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ort_pkg::out_t      out_item_o
);

  import ort_pkg::*;

  localparam int unsigned R      = REGIONS_PER_AXIS;
  localparam int unsigned ROWS   = R * R;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CB     = $clog2(R);
  localparam int unsigned CBX    = CB + 1;
  localparam int unsigned Q_W    = COORD_W + 2;
  localparam int unsigned SIDE3  = REGION_SIDE * REGION_SIDE * REGION_SIDE;
  localparam int unsigned PER    = (SIDE3 / 64 == 0) ? 1 : SIDE3 / 64;
  localparam int unsigned SHIFT  = WORD_IDX_W + $clog2(PER);
  localparam int unsigned RECIP  = ((2 ** SHIFT) + PER - 1) / PER;
  localparam int unsigned PROD_W = WORD_IDX_W + SHIFT + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e               state_q;
  logic                 out_valid_q;
  out_t                 out_item_q;
  logic                 accept;
  logic                 out_free;
  logic                 capture;

  logic                 ld_q;
  logic                 clr_q;
  logic [PROD_W-1:0]    prod_q;
  logic [WORD_IDX_W-1:0] region;
  logic [CB-1:0]        lx;
  logic [CB-1:0]        ly;
  logic [CB-1:0]        lz;
  logic                 in_grid;
  logic                 wr_en;
  logic [ROW_W-1:0]     wr_row;

  logic                 q_start;
  logic                 q_inside;
  logic [ROW_W-1:0]     q_trow;
  logic [ROW_W-1:0]     rd_row;
  logic [R-1:0]         rd_bits;
  logic                 scan_done;
  out_t                 scan_result;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign q_start    = accept && (in_item_i.cmd == CMD_QUERY);

  // Load/clear stage: region index by reciprocal multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q  <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      ld_q  <= accept && (in_item_i.cmd == CMD_LOAD) && (|in_item_i.grid_word);
      clr_q <= accept && (in_item_i.cmd == CMD_CLEAR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= PROD_W'(in_item_i.word_index) * PROD_W'(RECIP);
    end
  end

  assign region = prod_q[SHIFT +: WORD_IDX_W];

  always_comb begin
    for (int i = 0; i < CB; i++) begin
      lx[i] = region[3*i];
      ly[i] = region[3*i+1];
      lz[i] = region[3*i+2];
    end
  end

  assign in_grid = ((region >> (3 * CB)) == '0) &&
                   ({1'b0, lx} < CBX'(R)) &&
                   ({1'b0, ly} < CBX'(R)) &&
                   ({1'b0, lz} < CBX'(R));
  assign wr_en   = ld_q && in_grid;
  assign wr_row  = ROW_W'(ly) + ROW_W'(R) * ROW_W'(lz);

  // Query target
  assign q_inside = ({2'b00, in_item_i.region_x} < Q_W'(R)) &&
                    ({2'b00, in_item_i.region_y} < Q_W'(R)) &&
                    ({2'b00, in_item_i.region_z} < Q_W'(R));
  assign q_trow   = ROW_W'(in_item_i.region_y) +
                    ROW_W'(R) * ROW_W'(in_item_i.region_z);

  ort_flag_mem #(
    .REGIONS_PER_AXIS (R)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr_q),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .wr_bit_i  (lx),
    .rd_row_i  (rd_row),
    .rd_bits_o (rd_bits)
  );

  ort_scan #(
    .REGIONS_PER_AXIS (R)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (q_start),
    .qx_i      (in_item_i.region_x),
    .trow_i    (q_trow),
    .inside_i  (q_inside),
    .rd_row_o  (rd_row),
    .rd_bits_i (rd_bits),
    .done_o    (scan_done),
    .result_o  (scan_result)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign capture  = out_free &&
                    (((state_q == ST_SCAN) && scan_done) || (state_q == ST_HOLD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_start) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= capture ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (capture) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (capture) begin
        out_valid_q <= 1'b1;
        out_item_q  <= scan_result;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ sv/ort_checker.sv @@
// ----------------------------------------------------------------------------
// ort_checker
// Port-level checks for the occupancy region offset table.
// ----------------------------------------------------------------------------
`default_nettype none

module ort_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire ort_pkg::in_t  in_item_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire ort_pkg::out_t out_item_o
);

  import ort_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  a_empty_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.is_occupied |->
      out_item_o.offset == out_item_o.occupied_total)
    else $error("empty region offset differs from total");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.cmd == CMD_QUERY) |=> in_stall_o)
    else $error("input not stalled during query");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a query in flight");

endmodule

bind occupancy_region_offset_table ort_checker u_ort_checker (.*);

`default_nettype wire

@@ tb/tb_occupancy_region_offset_table.sv @@
// ----------------------------------------------------------------------------
// tb_occupancy_region_offset_table
// Self-checking bench for the occupancy region offset table. Grid word loads,
// region queries, clears and unused commands are driven with random gaps;
// the result side stalls at random and twice holds off for a long stretch.
// A scoreboard keeps its own copy of the region flags, predicts each query
// answer when the query is accepted and compares every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_occupancy_region_offset_table;
  import ort_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 1750;
  localparam int TAIL_CYCLES  = 100;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 10;

  class offset_scoreboard;
    logic [511:0] region_flags;
    out_t         expected_q[$];
    int           failures;
    int           results_seen;
    int           loads;
    int           queries;
    int           clears;
    int           ignored;
    int           occupied_hits;
    int           peak_total;

    function new();
      region_flags  = '0;
      failures      = 0;
      results_seen  = 0;
      loads         = 0;
      queries       = 0;
      clears        = 0;
      ignored       = 0;
      occupied_hits = 0;
      peak_total    = 0;
    endfunction

    function logic [8:0] zcode(logic [2:0] x, logic [2:0] y, logic [2:0] z);
      logic [8:0] m;
      for (int i = 0; i < 3; i++) begin
        m[3*i]   = x[i];
        m[3*i+1] = y[i];
        m[3*i+2] = z[i];
      end
      return m;
    endfunction

    function out_t region_offset(logic [2:0] qx, logic [2:0] qy, logic [2:0] qz);
      out_t       res;
      int         total;
      int         lower;
      logic [8:0] lin;
      logic [8:0] target;
      logic       occ;
      total  = 0;
      lower  = 0;
      target = {qz, qy, qx};
      for (int n = 0; n < 512; n++) begin
        lin = n[8:0];
        if (region_flags[zcode(lin[2:0], lin[5:3], lin[8:6])]) begin
          total++;
          if (lin < target) lower++;
        end
      end
      occ                = region_flags[zcode(qx, qy, qz)];
      res.offset         = occ ? lower[COUNT_W-1:0] : total[COUNT_W-1:0];
      res.occupied_total = total[COUNT_W-1:0];
      res.is_occupied    = occ;
      return res;
    endfunction

    function void note_item(in_t it);
      out_t res;
      if (it.cmd == CMD_LOAD) begin
        loads++;
        if (it.grid_word != '0) region_flags[it.word_index[14:6]] = 1'b1;
      end else if (it.cmd == CMD_CLEAR) begin
        clears++;
        region_flags = '0;
      end else if (it.cmd == CMD_QUERY) begin
        queries++;
        res = region_offset(it.region_x, it.region_y, it.region_z);
        if (res.is_occupied) occupied_hits++;
        if (int'(res.occupied_total) > peak_total) peak_total = int'(res.occupied_total);
        expected_q.insert(expected_q.size(), res);
      end else begin
        ignored++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("ERROR: result with none pending: offset %0d total %0d occ %0b",
                   got.offset, got.occupied_total, got.is_occupied);
        return;
      end
      want = expected_q.pop_front();
      if (got.offset !== want.offset || got.occupied_total !== want.occupied_total ||
          got.is_occupied !== want.is_occupied) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("ERROR: result %0d: exp offset %0d total %0d occ %0b, got %0d %0d %0b",
                   results_seen, want.offset, want.occupied_total, want.is_occupied,
                   got.offset, got.occupied_total, got.is_occupied);
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  offset_scoreboard sb;
  int               items_sent = 0;
  bit               tx_burst   = 1'b0;
  bit               rx_long    = 1'b0;
  logic [8:0]       recent_region = '0;

  occupancy_region_offset_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64'd1 << $urandom_range(0, 63);
      2:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_t rand_item(logic [CMD_W-1:0] cmd);
    in_t it;
    it.cmd        = cmd;
    it.word_index = WORD_IDX_W'($urandom);
    it.grid_word  = {$urandom, $urandom};
    it.region_x   = COORD_W'($urandom);
    it.region_y   = COORD_W'($urandom);
    it.region_z   = COORD_W'($urandom);
    return it;
  endfunction

  task automatic send(in_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_load(logic [WORD_IDX_W-1:0] idx, logic [63:0] word);
    in_t it;
    it            = rand_item(CMD_LOAD);
    it.word_index = idx;
    it.grid_word  = word;
    recent_region = idx[14:6];
    send(it);
  endtask

  task automatic send_query(logic [2:0] x, logic [2:0] y, logic [2:0] z);
    in_t it;
    it          = rand_item(CMD_QUERY);
    it.region_x = x;
    it.region_y = y;
    it.region_z = z;
    send(it);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int hold;
    int holds_done;
    bit rx_burst;
    holds_done = 0;
    rx_burst   = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, 3);
      if ((holds_done == 0 && sb.results_seen >= 25) ||
          (holds_done == 1 && sb.results_seen >= 150)) begin
        hold = LONG_HOLD;
        holds_done++;
      end
      if (hold > 0) begin
        if (hold == LONG_HOLD) rx_long = 1'b1;
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        rx_long = 1'b0;
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [8:0]  r;
    logic [63:0] w;
    int          kind;
    int          len;
    bit          sweep_done;
    sb         = new();
    sweep_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty grid, zero words, sticky flags, far corner, clear
    send_query(3'd0, 3'd0, 3'd0);
    send_query(3'd7, 3'd7, 3'd7);
    send_load(15'd0, 64'd0);
    send_query(3'd0, 3'd0, 3'd0);
    send_load(15'd0, '1);
    send_load(15'h7FFF, 64'd1);
    send_load(15'h7FC0, 64'd0);
    send(rand_item(CMD_UNUSED));
    send_query(3'd0, 3'd0, 3'd0);
    send_query(3'd7, 3'd7, 3'd7);
    send_query(3'd3, 3'd4, 3'd5);
    send_load({sb.zcode(3'd3, 3'd4, 3'd5), 6'd63}, 64'h8000_0000_0000_0000);
    send_query(3'd3, 3'd4, 3'd5);
    send_query(3'd7, 3'd7, 3'd7);
    send(rand_item(CMD_CLEAR));
    send_query(3'd7, 3'd7, 3'd7);
    send_load(15'd64, 64'h0000_0000_8000_0000);
    send_query(3'd1, 3'd0, 3'd0);
    send_query(3'd0, 3'd0, 3'd0);
    wait_results_drained();

    while (items_sent < TARGET_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      kind     = $urandom_range(0, 39);
      // keep queries coming while the result side is held off
      if (rx_long) kind = 39;
      if (kind == 0) begin
        send(rand_item(CMD_CLEAR));
      end else if (kind < 3) begin
        send(rand_item(CMD_UNUSED));
      end else if (kind < 25) begin
        len = $urandom_range(1, 24);
        repeat (len) send_load(WORD_IDX_W'($urandom), pick_word());
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          if ($urandom_range(0, 1) == 0)
            send_query({recent_region[6], recent_region[3], recent_region[0]},
                       {recent_region[7], recent_region[4], recent_region[1]},
                       {recent_region[8], recent_region[5], recent_region[2]});
          else
            send_query(3'($urandom), 3'($urandom), 3'($urandom));
        end
      end

      if (!sweep_done && items_sent >= 600) begin
        // fill every region, then probe the extremes of a full grid
        sweep_done = 1'b1;
        wait_results_drained();
        for (int n = 0; n < 512; n++) begin
          r = n[8:0];
          w = pick_word();
          if (w == '0) w = 64'h8000_0000_0000_0000;
          send_load({r, 6'($urandom)}, w);
        end
        send_query(3'd7, 3'd7, 3'd7);
        send_query(3'd0, 3'd0, 3'd0);
        repeat (4) send_query(3'($urandom), 3'($urandom), 3'($urandom));
        wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d loads, %0d queries, %0d clears, %0d unused commands accepted",
             sb.loads, sb.queries, sb.clears, sb.ignored);
    $display("Checked %0d results, %0d on occupied regions, peak occupied count %0d",
             sb.results_seen, sb.occupied_hits, sb.peak_total);
    if (sb.expected_q.size() != 0)
      $display("ERROR: %0d results never arrived", sb.expected_q.size());
    if (sb.failures > MAX_REPORTS)
      $display("%0d mismatches in total", sb.failures);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("ERROR: timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
